FILE: rtl/core/dtl_pkg.sv
package dtl_pkg;

  // Field and register widths
  localparam int SECONDS_W  = 8;
  localparam int TIMER_W    = 16;
  localparam int IDLE_W     = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;

  localparam int TICKS_PER_UNIT_DEF = 150;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // Register reset values
  localparam logic [SECONDS_W-1:0] GREEN_SECONDS_RST = 8'd10;
  localparam logic [SECONDS_W-1:0] AFTER_SECONDS_RST = 8'd5;
  localparam logic                 LAMP_OFF_EN_RST   = 1'b1;
  localparam logic [IDLE_W-1:0]    IDLE_TICKS_RST    = 17'd90000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GREEN_IN     = 3'd0,
    CFG_GREEN_OUT    = 3'd1,
    CFG_AFTER_IN     = 3'd2,
    CFG_AFTER_OUT    = 3'd3,
    CFG_LAMP_OFF_EN  = 3'd4,
    CFG_LAMP_OFF_TCK = 3'd5
  } dtl_cfg_idx_e;

  // Red lamp codes
  localparam logic [1:0] RED_OFF   = 2'd0;
  localparam logic [1:0] RED_ON    = 2'd1;
  localparam logic [1:0] RED_FLASH = 2'd2;

  typedef struct packed {
    logic request_in;
    logic request_out;
    logic door_closed_sw;
    logic door_open_sw;
  } dtl_in_t;

  typedef struct packed {
    logic       green_in_lamp;
    logic       green_out_lamp;
    logic [1:0] red_outside_lamp;
    logic [1:0] red_inside_lamp;
    logic       open_request;
  } dtl_out_t;

  typedef struct packed {
    logic [SECONDS_W-1:0] green_in_seconds;
    logic [SECONDS_W-1:0] green_out_seconds;
    logic [SECONDS_W-1:0] after_in_seconds;
    logic [SECONDS_W-1:0] after_out_seconds;
    logic                 lamp_off_enable;
    logic [IDLE_W-1:0]    lamp_off_ticks;
  } dtl_cfg_t;

endpackage

FILE: rtl/core/dtl_cfg.sv
module dtl_cfg
  import dtl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output dtl_cfg_t              cfg_o
);

  dtl_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (dtl_cfg_idx_e'(cfg_idx_i))
        CFG_GREEN_IN:     cfg_d.green_in_seconds  = cfg_wdata_i[SECONDS_W-1:0];
        CFG_GREEN_OUT:    cfg_d.green_out_seconds = cfg_wdata_i[SECONDS_W-1:0];
        CFG_AFTER_IN:     cfg_d.after_in_seconds  = cfg_wdata_i[SECONDS_W-1:0];
        CFG_AFTER_OUT:    cfg_d.after_out_seconds = cfg_wdata_i[SECONDS_W-1:0];
        CFG_LAMP_OFF_EN:  cfg_d.lamp_off_enable   = cfg_wdata_i[0];
        CFG_LAMP_OFF_TCK: cfg_d.lamp_off_ticks    = cfg_wdata_i[IDLE_W-1:0];
        default:          cfg_d = cfg_q;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.green_in_seconds  <= GREEN_SECONDS_RST;
      cfg_q.green_out_seconds <= GREEN_SECONDS_RST;
      cfg_q.after_in_seconds  <= AFTER_SECONDS_RST;
      cfg_q.after_out_seconds <= AFTER_SECONDS_RST;
      cfg_q.lamp_off_enable   <= LAMP_OFF_EN_RST;
      cfg_q.lamp_off_ticks    <= IDLE_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/dtl_core.sv
module dtl_core
  import dtl_pkg::*;
#(
  parameter int TICKS_PER_UNIT = TICKS_PER_UNIT_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     advance_i,
  input  dtl_in_t  item_i,
  input  dtl_cfg_t cfg_i,
  output dtl_out_t result_o
);

  localparam int TPU_W  = $clog2(TICKS_PER_UNIT + 1);
  localparam int PROD_W = (SECONDS_W + TPU_W > TIMER_W) ? SECONDS_W + TPU_W : TIMER_W + 1;
  localparam logic [TPU_W-1:0] TPU = TPU_W'(TICKS_PER_UNIT);

  // seconds scaled to half-rate ticks, saturated to the timer width
  function automatic logic [TIMER_W-1:0] preset(input logic [SECONDS_W-1:0] sec);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sec) * PROD_W'(TPU);
    return (prod > PROD_W'(TIMER_MAX)) ? TIMER_MAX : prod[TIMER_W-1:0];
  endfunction

  function automatic logic [1:0] red_code(input logic hard_on, input logic flash,
                                          input logic other_green, input logic idle_nz);
    logic [1:0] code;
    priority if (hard_on)                          code = RED_ON;
    else if (!flash && !other_green && idle_nz)    code = RED_ON;
    else if (flash && !other_green)                code = RED_FLASH;
    else                                           code = RED_OFF;
    return code;
  endfunction

  logic               tog_q, tog_d;
  logic               il_q, il_d, ol_q, ol_d, ip_q, ip_d, op_q, op_d;
  logic               gis_q, gis_d, gos_q, gos_d;
  logic [TIMER_W-1:0] gin_t_q, gin_t_d, gout_t_q, gout_t_d;
  logic [TIMER_W-1:0] ain_t_q, ain_t_d, aout_t_q, aout_t_d;
  logic [IDLE_W-1:0]  idle_q, idle_d;
  logic               flash;

  always_comb begin
    tog_d = !tog_q;

    priority if (!item_i.door_closed_sw)                  idle_d = cfg_i.lamp_off_ticks;
    else if (idle_q != '0 && cfg_i.lamp_off_enable)       idle_d = idle_q - 1'b1;
    else                                                  idle_d = idle_q;

    il_d = (item_i.request_in || il_q || ip_q) && !ol_q && (gin_t_q != '0);
    ol_d = (item_i.request_out || ol_q || op_q) && !il_d && (gout_t_q != '0);
    ip_d = ((item_i.request_in && ol_d) || ip_q) && !il_d;
    op_d = ((item_i.request_out && il_d) || op_q) && !ol_d;

    flash = (il_d || ol_d) && !item_i.door_open_sw;
    result_o.open_request = il_d || ol_d || gis_q || gos_q;

    // outbound green is decided first and seen by the inbound side
    gos_d = ol_d && item_i.door_open_sw && !gis_q && (ain_t_q == '0);
    if (gos_d && !item_i.request_out) begin
      gout_t_d = (gout_t_q != '0 && tog_d) ? gout_t_q - 1'b1 : gout_t_q;
      aout_t_d = preset(cfg_i.after_out_seconds);
    end else begin
      gout_t_d = preset(cfg_i.green_out_seconds);
      aout_t_d = (aout_t_q != '0 && tog_d) ? aout_t_q - 1'b1 : aout_t_q;
    end

    result_o.red_outside_lamp = red_code((il_d && !gos_d) || gis_q, flash, gos_d,
                                         idle_d != '0);

    gis_d = il_d && item_i.door_open_sw && !gos_d && (aout_t_d == '0);
    if (gis_d && !item_i.request_in) begin
      gin_t_d = (gin_t_q != '0 && tog_d) ? gin_t_q - 1'b1 : gin_t_q;
      ain_t_d = preset(cfg_i.after_in_seconds);
    end else begin
      gin_t_d = preset(cfg_i.green_in_seconds);
      ain_t_d = (ain_t_q != '0 && tog_d) ? ain_t_q - 1'b1 : ain_t_q;
    end

    result_o.red_inside_lamp = red_code((ol_d && !gis_d) || gos_d, flash, gis_d,
                                        idle_d != '0);

    result_o.green_in_lamp  = gis_d;
    result_o.green_out_lamp = gos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tog_q    <= 1'b0;
      il_q     <= 1'b0;
      ol_q     <= 1'b0;
      ip_q     <= 1'b0;
      op_q     <= 1'b0;
      gis_q    <= 1'b0;
      gos_q    <= 1'b0;
      gin_t_q  <= '0;
      gout_t_q <= '0;
      ain_t_q  <= '0;
      aout_t_q <= '0;
      idle_q   <= IDLE_TICKS_RST;
    end else if (advance_i) begin
      tog_q    <= tog_d;
      il_q     <= il_d;
      ol_q     <= ol_d;
      ip_q     <= ip_d;
      op_q     <= op_d;
      gis_q    <= gis_d;
      gos_q    <= gos_d;
      gin_t_q  <= gin_t_d;
      gout_t_q <= gout_t_d;
      ain_t_q  <= ain_t_d;
      aout_t_q <= aout_t_d;
      idle_q   <= idle_d;
    end
  end

  a_one_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(gis_q && gos_q)) else $error("both green lamps on");

  a_one_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(il_q && ol_q)) else $error("both directions latched");

  a_pend_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(il_q && ip_q) && !(ol_q && op_q)) else $error("latched direction still pending");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(idle_q) && $stable(tog_q)) else $error("state moved without item");

endmodule

FILE: rtl/core/dtl_out_buf.sv
module dtl_out_buf
  import dtl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  dtl_out_t data_i,
  output logic     full_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dtl_out_t out_o
);

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  dtl_out_t out_q, out_d, skid_q, skid_d;
  logic     pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = push_i;
        skid_d       = data_i;
      end else begin
        out_valid_d = push_i;
        out_d       = data_i;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q) else $error("skid holds item ahead of output");

endmodule

FILE: rtl/core/door_traffic_light_interlock.sv
// An accepted item waits in the input register; its result is registered in the output buffer.
// Throughput: one item per cycle while the output is not stalled; the tick
//   logic is a single pass between the input register and the output buffer.
// The two-entry output buffer lets one more item in while a result waits.
// Reset (asynchronous, active low) clears all latches and timers, loads the
//   idle timer with 90000 and the registers with their default presets.
module door_traffic_light_interlock
  import dtl_pkg::*;
#(
  parameter int TICKS_PER_UNIT = TICKS_PER_UNIT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tick items in
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  dtl_in_t               in_i,
  // lamp results out
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output dtl_out_t              out_o,
  // register writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic     in_valid_q;
  dtl_in_t  in_q;
  logic     advance;
  logic     buf_full;
  dtl_cfg_t cfg;
  dtl_out_t result;

  // Advance the registered item through the tick logic whenever the
  // output buffer has room; the interlock state updates at the same edge.
  assign advance    = in_valid_q && !buf_full;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Hold the payload while stalled; load it on every accepted item.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_i;
    end
  end

  dtl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Latches, pending bits, countdowns and lamp decisions for one tick.
  dtl_core #(
    .TICKS_PER_UNIT (TICKS_PER_UNIT)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  // Output register plus skid entry decouple the stall from the tick logic.
  dtl_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance),
    .data_i      (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  a_stall_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && buf_full) else $error("input stalled with buffer room");

endmodule

FILE: tb/sv/tb_door_traffic_light_interlock.sv
`timescale 1ns / 1ps

module tb_door_traffic_light_interlock;
  import dtl_pkg::*;

  // Allow for the slowest phase (receiver stall chance 86 percent) several times over.
  localparam int CYCLE_LIMIT  = 400000;
  // Margin at the end of the run, after every owed result has come out.
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 60;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  dtl_in_t               tick_in   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  dtl_out_t              lamps_out;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned reports        = 0;
  int unsigned cycles         = 0;

  // Lamp results still owed by the block, oldest first.
  dtl_out_t lamps_expected[$];

  door_traffic_light_interlock dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (tick_in),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (lamps_out),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Interlock predictor: presets, latches and timers kept in step with the block
  // ---------------------------------------------------------------------------
  logic [SECONDS_W-1:0] green_in_secs, green_out_secs, after_in_secs, after_out_secs;
  logic                 lamp_off_en;
  logic [IDLE_W-1:0]    lamp_off_preset;

  logic                 half_tick;
  logic                 in_latch, out_latch, in_pending, out_pending;
  logic                 green_in_on, green_out_on;
  logic [TIMER_W-1:0]   green_in_left, green_out_left, after_in_left, after_out_left;
  logic [IDLE_W-1:0]    idle_left;

  function automatic void reset_interlock();
    green_in_secs   = GREEN_SECONDS_RST;
    green_out_secs  = GREEN_SECONDS_RST;
    after_in_secs   = AFTER_SECONDS_RST;
    after_out_secs  = AFTER_SECONDS_RST;
    lamp_off_en     = LAMP_OFF_EN_RST;
    lamp_off_preset = IDLE_TICKS_RST;
    half_tick       = 1'b0;
    in_latch        = 1'b0;
    out_latch       = 1'b0;
    in_pending      = 1'b0;
    out_pending     = 1'b0;
    green_in_on     = 1'b0;
    green_out_on    = 1'b0;
    green_in_left   = '0;
    green_out_left  = '0;
    after_in_left   = '0;
    after_out_left  = '0;
    idle_left       = IDLE_TICKS_RST;
  endfunction

  // Scale seconds to half-rate ticks; clip at the timer width.
  function automatic logic [TIMER_W-1:0] seconds_to_ticks(logic [SECONDS_W-1:0] secs);
    int unsigned scaled;
    scaled = secs * TICKS_PER_UNIT_DEF;
    return (scaled > TIMER_MAX) ? TIMER_MAX : scaled[TIMER_W-1:0];
  endfunction

  // Hard on wins; otherwise steady red only while the idle timer runs, flashing
  // while a side is latched and the door is not fully open, and dark whenever the other side shows green.
  function automatic logic [1:0] red_lamp(logic hard_on, logic flash, logic other_green);
    if (hard_on) return RED_ON;
    if (!flash && !other_green && idle_left != 0) return RED_ON;
    if (flash && !other_green) return RED_FLASH;
    return RED_OFF;
  endfunction

  // Advance the interlock by one tick and return the lamps it shows.
  function automatic dtl_out_t predict_lamps(dtl_in_t t);
    dtl_out_t lamps;
    logic     flash;
    logic     open_req;

    half_tick = !half_tick;

    if (!t.door_closed_sw) idle_left = lamp_off_preset;
    else if (idle_left != 0 && lamp_off_en) idle_left = idle_left - 1'b1;

    // Latch one direction at a time; a request against the holder waits as pending.
    in_latch    = (t.request_in || in_latch || in_pending) && !out_latch &&
                  green_in_left != 0;
    out_latch   = (t.request_out || out_latch || out_pending) && !in_latch &&
                  green_out_left != 0;
    in_pending  = ((t.request_in && out_latch) || in_pending) && !in_latch;
    out_pending = ((t.request_out && in_latch) || out_pending) && !out_latch;

    flash    = (in_latch || out_latch) && !t.door_open_sw;
    open_req = in_latch || out_latch || green_in_on || green_out_on;

    // Outbound side first: it still sees last tick's inbound green.
    green_out_on = out_latch && t.door_open_sw && !green_in_on && after_in_left == 0;
    if (green_out_on && !t.request_out) begin
      if (green_out_left != 0 && half_tick) green_out_left = green_out_left - 1'b1;
      after_out_left = seconds_to_ticks(after_out_secs);
    end else begin
      green_out_left = seconds_to_ticks(green_out_secs);
      if (after_out_left != 0 && half_tick) after_out_left = after_out_left - 1'b1;
    end

    lamps.red_outside_lamp = red_lamp((in_latch && !green_out_on) || green_in_on, flash,
                                      green_out_on);

    green_in_on = in_latch && t.door_open_sw && !green_out_on && after_out_left == 0;
    if (green_in_on && !t.request_in) begin
      if (green_in_left != 0 && half_tick) green_in_left = green_in_left - 1'b1;
      after_in_left = seconds_to_ticks(after_in_secs);
    end else begin
      green_in_left = seconds_to_ticks(green_in_secs);
      if (after_in_left != 0 && half_tick) after_in_left = after_in_left - 1'b1;
    end

    lamps.red_inside_lamp = red_lamp((out_latch && !green_in_on) || green_out_on, flash,
                                     green_in_on);
    lamps.green_in_lamp   = green_in_on;
    lamps.green_out_lamp  = green_out_on;
    lamps.open_request    = open_req;
    return lamps;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  function automatic dtl_in_t make_tick(logic req_in, logic req_out, logic shut,
                                        logic fully_open);
    dtl_in_t t;
    t.request_in     = req_in;
    t.request_out    = req_out;
    t.door_closed_sw = shut;
    t.door_open_sw   = fully_open;
    return t;
  endfunction

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_gap_pct   = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Send one tick item; predict its lamps once the block has taken it.
  // Stall is sampled at the falling edge, where nothing is moving.
  task automatic send_tick(dtl_in_t t);
    logic stalled;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    tick_in  <= t;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    lamps_expected.push_back(predict_lamps(t));
  endtask

  task automatic send_ticks(int unsigned count, dtl_in_t t);
    repeat (count) send_tick(t);
  endtask

  // Hold off the sender until every owed result has come out.
  task automatic wait_lamps_drained();
    in_valid <= 1'b0;
    while (lamps_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; the predictor follows at the same edge.
  task automatic write_reg(dtl_cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_GREEN_IN:     green_in_secs   = value[SECONDS_W-1:0];
      CFG_GREEN_OUT:    green_out_secs  = value[SECONDS_W-1:0];
      CFG_AFTER_IN:     after_in_secs   = value[SECONDS_W-1:0];
      CFG_AFTER_OUT:    after_out_secs  = value[SECONDS_W-1:0];
      CFG_LAMP_OFF_EN:  lamp_off_en     = value[0];
      CFG_LAMP_OFF_TCK: lamp_off_preset = value[IDLE_W-1:0];
      default: ;
    endcase
  endtask

  // Rewrite every preset, only once the block has gone quiet.
  task automatic apply_presets(int unsigned gin, int unsigned gout, int unsigned ain,
                               int unsigned aout, int unsigned en, int unsigned idle_ticks);
    wait_lamps_drained();
    write_reg(CFG_GREEN_IN, CFG_DATA_W'(gin));
    write_reg(CFG_GREEN_OUT, CFG_DATA_W'(gout));
    write_reg(CFG_AFTER_IN, CFG_DATA_W'(ain));
    write_reg(CFG_AFTER_OUT, CFG_DATA_W'(aout));
    write_reg(CFG_LAMP_OFF_EN, CFG_DATA_W'(en));
    write_reg(CFG_LAMP_OFF_TCK, CFG_DATA_W'(idle_ticks));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiving and checking
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic bit field_matches(string name, logic [1:0] want, logic [1:0] got);
    if (got === want) return 1'b1;
    if (reports < MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    reports++;
    return 1'b0;
  endfunction

  // A result moves at the next rising edge when valid is up and stall is down;
  // look at it on the falling edge before that.
  always @(negedge clk) begin
    dtl_out_t want;
    bit       fields_ok;
    if (rst_n && out_valid && !out_stall) begin
      if (lamps_expected.size() == 0) begin
        mismatches++;
        if (reports < MAX_REPORTS)
          $display("%0t: unexpected lamp item, expected none, actual %p", $time, lamps_out);
        reports++;
      end else begin
        want      = lamps_expected.pop_front();
        fields_ok = field_matches("green_in_lamp", 2'(want.green_in_lamp),
                                  2'(lamps_out.green_in_lamp));
        fields_ok &= field_matches("green_out_lamp", 2'(want.green_out_lamp),
                                   2'(lamps_out.green_out_lamp));
        fields_ok &= field_matches("red_outside_lamp", want.red_outside_lamp,
                                   lamps_out.red_outside_lamp);
        fields_ok &= field_matches("red_inside_lamp", want.red_inside_lamp,
                                   lamps_out.red_inside_lamp);
        fields_ok &= field_matches("open_request", 2'(want.open_request),
                                   2'(lamps_out.open_request));
        if (!fields_ok) mismatches++;
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("door_traffic_light_interlock verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset the green timers are empty, so a request on the very first
  // tick must not latch. Then walk every switch and request combination.
  task automatic test_first_tick_and_switches();
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b1));
    for (int unsigned combo = 0; combo < 16; combo++)
      send_tick(dtl_in_t'(combo[3:0]));
    // Hold an inbound request at an open door, then release it.
    send_ticks(3, make_tick(1'b1, 1'b0, 1'b0, 1'b1));
    send_ticks(3, make_tick(1'b0, 1'b0, 1'b0, 1'b1));
  endtask

  // Mostly whole passages with random content, mixed with loose switch noise.
  task automatic test_random_traffic(int unsigned item_count);
    int unsigned sent;
    int unsigned dir;
    int unsigned hold;
    logic        req_in;
    logic        req_out;
    sent = 0;
    while (sent < item_count) begin
      // Now and then let the block run dry before the next passage.
      if ($urandom_range(39) == 0) wait_lamps_drained();
      if ($urandom_range(9) < 7) begin
        dir     = $urandom_range(2);
        req_in  = (dir != 1);
        req_out = (dir != 0);
        // Request at the shut door.
        hold = $urandom_range(1, 3);
        repeat (hold) begin
          send_tick(make_tick(req_in, req_out, 1'b1, 1'b0));
          sent++;
        end
        // Door swinging: neither switch made.
        hold = $urandom_range(1, 3);
        repeat (hold) begin
          send_tick(make_tick($urandom_range(5) == 0, $urandom_range(5) == 0, 1'b0, 1'b0));
          sent++;
        end
        // Door fully open while people pass; stray requests from either side.
        hold = $urandom_range(2, 30);
        repeat (hold) begin
          send_tick(make_tick($urandom_range(7) == 0, $urandom_range(7) == 0, 1'b0, 1'b1));
          sent++;
        end
        // Door shut again and left alone.
        hold = $urandom_range(1, 12);
        repeat (hold) begin
          send_tick(make_tick($urandom_range(9) == 0, $urandom_range(9) == 0, 1'b1, 1'b0));
          sent++;
        end
      end else begin
        send_tick(dtl_in_t'(4'($urandom_range(15))));
        sent++;
      end
    end
  endtask

  // Run the inbound green countdown to its end with a one-second preset while
  // outbound waits pending; outbound then latches and sits out the clearance,
  // and the door shuts with the short idle preset running down.
  task automatic test_green_expiry();
    apply_presets(1, 1, 1, 1, 1, 25);
    send_ticks(2, make_tick(1'b0, 1'b0, 1'b1, 1'b0));
    send_tick(make_tick(1'b1, 1'b0, 1'b1, 1'b0));
    send_ticks(3, make_tick(1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1));
    // Outbound asks while inbound holds: goes pending.
    send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b1));
    // Inbound green runs out and hands over to the pending outbound side.
    send_ticks(310, make_tick(1'b0, 1'b0, 1'b0, 1'b1));
    send_ticks(20, make_tick(1'b0, 1'b0, 1'b1, 1'b0));
  endtask

  initial begin
    reset_interlock();
    set_idling(37, 86);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_tick_and_switches();

    apply_presets($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(0, 1),
                  $urandom_range(0, 1), 1, $urandom_range(1, 12));
    test_random_traffic(30);

    set_idling(86, 37);
    apply_presets(255, 0, 255, 3, 0, 131071);
    test_random_traffic(30);

    set_idling(0, 0);
    apply_presets(0, 255, 0, 0, 1, 0);
    test_random_traffic(30);
    test_green_expiry();

    wait_lamps_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && lamps_expected.size() == 0) begin
      $display("door_traffic_light_interlock verification clean");
    end else begin
      $display("door_traffic_light_interlock verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/dtl_pkg.sv
rtl/core/dtl_cfg.sv
rtl/core/dtl_core.sv
rtl/core/dtl_out_buf.sv
rtl/core/door_traffic_light_interlock.sv
tb/sv/tb_door_traffic_light_interlock.sv
